// ===== rtl/cdq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdq_pkg: shared types and constants of the circular deque
// Operation and status codes, controller states and the command bundle
// that the controller sends to the datapath.
// ----------------------------------------------------------------------------
package cdq_pkg;

    // Widths fixed by the request and result formats
    localparam int OP_W     = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int POP_W    = 32;
    localparam int OCC_W    = 5;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_REAR  = 2'd0,
        OP_PUSH_FRONT = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_REAR   = 2'd3
    } cdq_op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } cdq_status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } cdq_state_t;

    typedef struct packed {
        logic accept;   // latch request, launch store read
        logic commit;   // update indices, write store, load result
    } cdq_cmd_t;

endpackage : cdq_pkg
`default_nettype wire

// ===== rtl/circular_deque.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Timing: the store read launches at the accepting edge; the execute state
//   then waits until the result register is free, and its commit edge
//   updates the indices and loads the result register.
// Flow: a new request waits until the last one has committed, since
//   the registered read of the single-read-port store precedes the index update.
// Reset: rst_n clears indices, held count and handshake state at once; the
//   store itself is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// circular_deque: double-ended queue over a circular word store
// Push or pop at either end; each request returns status, popped word and
// occupancy. A push to a full store and a pop from an empty one change nothing.
// ----------------------------------------------------------------------------
module circular_deque
    import cdq_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire                     clk,
    input  wire                     rst_n,
    // Request channel
    input  wire                     s_tvalid,
    output logic                    s_tready,
    input  wire  [IN_TDATA_W-1:0]   s_tdata,   // op[1:0], value[33:2], zero[39:34]
    // Result channel
    output logic                    m_tvalid,
    input  wire                     m_tready,
    output logic [OUT_TDATA_W-1:0]  m_tdata    // status[1:0], popped[33:2],
                                               // occupancy[38:34], zero[39]
);

    cdq_cmd_t            cmd;
    logic [STATUS_W-1:0] res_status;
    logic [POP_W-1:0]    res_popped;
    logic [OCC_W-1:0]    res_occupancy;

    // Controller: takes a request in idle, holds it in execute until the
    // result register can accept the outcome, then returns to idle. The
    // result register decouples the two sides, so a waiting result does not
    // block the next request.
    cdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd)
    );

    // Datapath: indices, count, store and result payload
    cdq_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .in_op         (s_tdata[OP_W-1:0]),
        .in_value      (s_tdata[OP_W +: VALUE_W]),
        .out_status    (res_status),
        .out_popped    (res_popped),
        .out_occupancy (res_occupancy)
    );

    // Pack the result, low field first, pad to whole bytes
    assign m_tdata = {
        {(OUT_TDATA_W - STATUS_W - POP_W - OCC_W){1'b0}},
        res_occupancy,
        res_popped,
        res_status
    };

endmodule : circular_deque
`default_nettype wire

// ===== rtl/cdq_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdq_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire                      clk,
    input  wire                      we,
    input  wire  [$clog2(DEPTH)-1:0] waddr,
    input  wire  [WIDTH-1:0]         wdata,
    input  wire                      re,
    input  wire  [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule : cdq_ram
`default_nettype wire

// ===== rtl/cdq_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdq_ctrl: deque controller
// Two-state sequencer plus the result valid flag; issues accept and commit.
// ----------------------------------------------------------------------------
module cdq_ctrl
    import cdq_pkg::*;
(
    input  wire       clk,
    input  wire       rst_n,
    input  wire       in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  wire       out_ready,
    output cdq_cmd_t  cmd
);

    cdq_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    // Result slot can take a new result when empty or draining this cycle
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        cmd.accept = 1'b0;
        cmd.commit = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            S_EXEC:
            begin
                cmd.commit = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule : cdq_ctrl
`default_nettype wire

// ===== rtl/cdq_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdq_datapath: deque datapath
// Head/tail indices, held count, word store and the result register.
// ----------------------------------------------------------------------------
module cdq_datapath
    import cdq_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire cdq_cmd_t       cmd,
    input  wire  [OP_W-1:0]     in_op,
    input  wire  [VALUE_W-1:0]  in_value,
    output logic [STATUS_W-1:0] out_status,
    output logic [POP_W-1:0]    out_popped,
    output logic [OCC_W-1:0]    out_occupancy
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [AW-1:0]         head_reg, head_next, tail_reg, tail_next;
    logic [CW-1:0]         count_reg, count_next;
    cdq_op_t               op_reg;
    logic [DATA_WIDTH-1:0] value_reg;
    logic [AW-1:0]         head_inc, head_dec, tail_inc, tail_dec;
    logic                  full, empty;
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr, ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;
    cdq_status_t           status;
    logic [POP_W-1:0]      popped;

    // Read launches with the request: front word for pop front, else rear
    assign ram_raddr = (cdq_op_t'(in_op) == OP_POP_FRONT) ? head_reg : tail_reg;

    cdq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (value_reg),
        .re    (cmd.accept),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);

    // Wrap-around neighbors of both indices
    assign head_inc = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign head_dec = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - 1'b1;
    assign tail_inc = (tail_reg == AW'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
    assign tail_dec = (tail_reg == '0) ? AW'(DEPTH - 1) : tail_reg - 1'b1;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        ram_we     = 1'b0;
        ram_waddr  = tail_inc;
        status     = ST_OK;
        popped     = '0;
        unique case (op_reg) inside
            OP_PUSH_REAR, OP_PUSH_FRONT:
            begin
                if (full)
                begin
                    status = ST_OVERFLOW;
                end
                else
                begin
                    ram_we     = cmd.commit;
                    count_next = count_reg + 1'b1;
                    if (empty)
                    begin
                        // First word always lands at index zero
                        head_next = '0;
                        tail_next = '0;
                        ram_waddr = '0;
                    end
                    else if (op_reg == OP_PUSH_REAR)
                    begin
                        tail_next = tail_inc;
                        ram_waddr = tail_inc;
                    end
                    else
                    begin
                        head_next = head_dec;
                        ram_waddr = head_dec;
                    end
                end
            end
            OP_POP_FRONT, OP_POP_REAR:
            begin
                if (empty)
                begin
                    status = ST_UNDERFLOW;
                end
                else
                begin
                    popped     = POP_W'($signed(ram_rdata));
                    count_next = count_reg - 1'b1;
                    if (op_reg == OP_POP_FRONT)
                    begin
                        head_next = head_inc;
                    end
                    else
                    begin
                        tail_next = tail_dec;
                    end
                    // Draining the last word parks both indices at zero
                    if (count_reg == CW'(1))
                    begin
                        head_next = '0;
                        tail_next = '0;
                    end
                end
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else if (cmd.commit)
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg    <= cdq_op_t'(in_op);
            value_reg <= DATA_WIDTH'(in_value);
        end
        if (cmd.commit)
        begin
            out_status    <= status;
            out_popped    <= popped;
            out_occupancy <= OCC_W'(count_next);
        end
    end

endmodule : cdq_datapath
`default_nettype wire

// ===== rtl/cdq_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdq_checker: port-level checks of the circular deque
// Watches the request and result channels; bound to the top level.
// ----------------------------------------------------------------------------
module cdq_checker
    import cdq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input wire                    clk,
    input wire                    rst_n,
    input wire                    s_tvalid,
    input wire                    s_tready,
    input wire                    m_tvalid,
    input wire                    m_tready,
    input wire [OUT_TDATA_W-1:0]  m_tdata
);

    // A request occupies the block while it is in its execute state
    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken in the cycle after a request");

    // Occupancy never exceeds the store depth
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (DEPTH > 31) || (int'(m_tdata[38:34]) <= DEPTH))
        else $error("occupancy above depth");

    // Only defined status codes appear
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[1:0] == ST_OK) || (m_tdata[1:0] == ST_OVERFLOW)
                     || (m_tdata[1:0] == ST_UNDERFLOW))
        else $error("undefined status code");

    // A failed request returns no word
    a_fail_no_word: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[1:0] != ST_OK) |-> (m_tdata[33:2] == '0))
        else $error("word returned with error status");

    // A stalled result stays offered
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result dropped or changed");

endmodule : cdq_checker

bind circular_deque cdq_checker #(.DEPTH(DEPTH)) u_cdq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the circular deque
// Drives push and pop requests at both ends through the request stream. It
// mirrors the deque contents to predict status, popped word and occupancy
// for every request. It compares each result word with the oldest prediction,
// while both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
    import cdq_pkg::*;

    localparam int SLOTS        = 16;
    localparam int WORD_W       = 32;
    localparam int RANDOM_ITEMS = 1626;

    typedef struct {
        cdq_status_t status;
        logic [POP_W-1:0] popped;
        logic [OCC_W-1:0] occupancy;
    } deque_reply_t;

    // Mirror of the deque: tracks contents and indices, queues the replies
    // that each accepted request must produce.
    class deque_mirror;
        logic [WORD_W-1:0] words [SLOTS];
        int unsigned head;
        int unsigned tail;
        int unsigned count;
        deque_reply_t awaited[$];
        int failures;

        function new();
            head = 0;
            tail = 0;
            count = 0;
            failures = 0;
        endfunction

        function int unsigned step_up(int unsigned idx);
            return (idx == SLOTS - 1) ? 0 : idx + 1;
        endfunction

        function int unsigned step_down(int unsigned idx);
            return (idx == 0) ? SLOTS - 1 : idx - 1;
        endfunction

        // Apply one accepted request to the mirror and queue its reply.
        function void note_request(cdq_op_t op, logic [VALUE_W-1:0] value);
            deque_reply_t r;
            r.status = ST_OK;
            r.popped = '0;
            if (op == OP_PUSH_REAR || op == OP_PUSH_FRONT) begin
                if (count == SLOTS) begin
                    r.status = ST_OVERFLOW;
                end
                else begin
                    // A push into an empty deque always lands in slot zero
                    if (count == 0) begin
                        head = 0;
                        tail = 0;
                        words[0] = value;
                    end
                    else if (op == OP_PUSH_REAR) begin
                        tail = step_up(tail);
                        words[tail] = value;
                    end
                    else begin
                        head = step_down(head);
                        words[head] = value;
                    end
                    count++;
                end
            end
            else begin
                if (count == 0) begin
                    r.status = ST_UNDERFLOW;
                end
                else begin
                    if (op == OP_POP_FRONT) begin
                        r.popped = words[head];
                        head = step_up(head);
                    end
                    else begin
                        r.popped = words[tail];
                        tail = step_down(tail);
                    end
                    count--;
                    // Emptying pop sends both indices home
                    if (count == 0) begin
                        head = 0;
                        tail = 0;
                    end
                end
            end
            r.occupancy = count[OCC_W-1:0];
            awaited.push_back(r);
        endfunction

        // Compare one result word with the oldest queued reply.
        function void check_result(logic [OUT_TDATA_W-1:0] data);
            deque_reply_t r;
            logic [STATUS_W-1:0] got_status;
            logic [POP_W-1:0] got_popped;
            logic [OCC_W-1:0] got_occ;
            got_status = data[1:0];
            got_popped = data[33:2];
            got_occ    = data[38:34];
            if (awaited.size() == 0) begin
                $display("%0t: result with no request pending, actual %h", $time, data);
                failures++;
                return;
            end
            r = awaited.pop_front();
            if (got_status !== r.status) begin
                $display("%0t: status expected %0d actual %0d", $time, r.status, got_status);
                failures++;
            end
            if (got_popped !== r.popped) begin
                $display("%0t: popped expected %h actual %h", $time, r.popped, got_popped);
                failures++;
            end
            if (got_occ !== r.occupancy) begin
                $display("%0t: occupancy expected %0d actual %0d",
                         $time, r.occupancy, got_occ);
                failures++;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_TDATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    // Set during bursts that run with no idling on either side
    bit quiet = 1'b0;

    deque_mirror mirror;

    circular_deque #(
        .DEPTH      (SLOTS),
        .DATA_WIDTH (WORD_W)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    // Idle length: mostly none, often a few cycles, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (quiet)
            return 0;
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    // Push value: mostly random, sometimes a corner of the signed range
    function automatic logic [VALUE_W-1:0] pick_word();
        int r;
        r = $urandom_range(99);
        if (r < 3)
            return 32'h0000_0000;
        if (r < 6)
            return 32'h7FFF_FFFF;
        if (r < 9)
            return 32'h8000_0000;
        if (r < 12)
            return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    // Present one request, hold it until accepted, then idle for gap cycles.
    task automatic send_request(cdq_op_t op, logic [VALUE_W-1:0] value, int gap);
        s_tdata  <= {6'b0, value, op};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        mirror.note_request(op, value);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Result side: alternate ready stretches with random stalls
    initial begin
        int run;
        int stall;
        forever begin
            m_tready <= 1'b1;
            run = $urandom_range(12, 1);
            repeat (run) @(posedge clk);
            stall = pick_gap();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    // Check every accepted result
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready)
            mirror.check_result(m_tdata);
    end

    initial begin
        int issued;
        int mode;
        int len;
        int r;
        bit push;
        cdq_op_t op;

        mirror = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Pops on an empty deque must underflow at either end
        send_request(OP_POP_FRONT, 32'hDEAD_BEEF, pick_gap());
        send_request(OP_POP_REAR, 32'h1234_5678, pick_gap());
        // Push front into empty, then a pop that empties again
        send_request(OP_PUSH_FRONT, 32'h8000_0000, pick_gap());
        send_request(OP_POP_REAR, 32'h0, pick_gap());

        // Fill from both ends so the indices wrap, with corner values
        for (int i = 0; i < SLOTS; i++) begin
            case (i % 4)
                0: send_request(OP_PUSH_REAR, 32'h7FFF_FFFF - i, pick_gap());
                1: send_request(OP_PUSH_FRONT, 32'hFFFF_FFFF, pick_gap());
                2: send_request(OP_PUSH_FRONT, 32'h0000_0000, pick_gap());
                default: send_request(OP_PUSH_REAR, 32'h8000_0000 + i, pick_gap());
            endcase
        end

        // Full: both pushes must overflow and leave contents alone
        send_request(OP_PUSH_REAR, 32'h5555_5555, pick_gap());
        send_request(OP_PUSH_FRONT, 32'hAAAA_AAAA, pick_gap());
        send_request(OP_POP_FRONT, 32'h0, pick_gap());
        send_request(OP_POP_REAR, 32'hFFFF_FFFF, pick_gap());

        // Random bursts, each leaning toward filling, draining or neither,
        // so the deque swings between full and empty many times.
        issued = 0;
        while (issued < RANDOM_ITEMS) begin
            mode  = $urandom_range(2);
            len   = $urandom_range(40, 8);
            quiet = ($urandom_range(5) == 0);
            repeat (len) begin
                r = $urandom_range(99);
                if (mode == 0)
                    push = (r < 80);
                else if (mode == 1)
                    push = (r < 20);
                else
                    push = (r < 50);
                if (push)
                    op = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
                else
                    op = $urandom_range(1) ? OP_POP_FRONT : OP_POP_REAR;
                send_request(op, pick_word(), pick_gap());
                issued++;
            end
        end
        quiet = 1'b0;
        s_tvalid <= 1'b0;

        // Drain outstanding results, then give stray ones a chance to show
        while (mirror.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (mirror.failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
